// ===== design/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, widths and constants of the two-link arm inverse kinematics
// unit: square-root and CORDIC cell payloads and the arctangent table.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int XW      = 50;   // CORDIC x/y width
  localparam int ZW      = 27;   // angle accumulator width, 1/65536 degree
  localparam int VW      = 60;   // square-root radicand width
  localparam int QW      = 30;   // square-root result width
  localparam int RW      = 33;   // square-root remainder width
  localparam int TAB_LEN = 24;

  localparam logic signed [ZW-1:0] ANG90  = 27'sd5898240;
  localparam logic signed [ZW-1:0] ANG180 = 27'sd11796480;
  localparam logic signed [ZW:0]   ELBOW_MAX    = 28'sd46080;
  localparam logic signed [ZW:0]   SHOULDER_MIN = -28'sd46080;
  localparam logic signed [ZW:0]   SHOULDER_MAX = 28'sd69120;

  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_BASE_Z = 3'd2;
  localparam logic [2:0] REG_UPPER  = 3'd3;
  localparam logic [2:0] REG_FORE   = 3'd4;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
  } sqrt_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic ok;      // target within reach
    logic ezero;   // dy and dz both zero
  } flags_t;

  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] r;
    unique case (i)
      0:  r = 22'd2949120;
      1:  r = 22'd1740967;
      2:  r = 22'd919879;
      3:  r = 22'd466945;
      4:  r = 22'd234379;
      5:  r = 22'd117304;
      6:  r = 22'd58666;
      7:  r = 22'd29335;
      8:  r = 22'd14668;
      9:  r = 22'd7334;
      10: r = 22'd3667;
      11: r = 22'd1833;
      12: r = 22'd917;
      13: r = 22'd458;
      14: r = 22'd229;
      15: r = 22'd115;
      16: r = 22'd57;
      17: r = 22'd29;
      18: r = 22'd14;
      19: r = 22'd7;
      20: r = 22'd4;
      21: r = 22'd2;
      22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/tlik_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_sqrt_cell
// One digit of a restoring integer square root: brings down two radicand
// bits, tries the next result bit and registers the partial result.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell #(
  parameter int BIT = 29
) (
  input  logic           clk,
  input  logic           en,
  input  tlik_pkg::sqrt_t d_i,
  output tlik_pkg::sqrt_t d_r
);
  import tlik_pkg::*;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;
  sqrt_t         d_nxt;

  always_comb begin
    rem_sh    = {d_i.rem[RW-3:0], d_i.v[2*BIT+1 -: 2]};
    trial     = {1'b0, d_i.q, 2'b01};
    ge        = (rem_sh >= trial);
    d_nxt.v   = d_i.v;
    d_nxt.rem = ge ? (rem_sh - trial) : rem_sh;
    d_nxt.q   = {d_i.q[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== design/tlik_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
module tlik_cordic_cell #(
  parameter int I = 0
) (
  input  logic             clk,
  input  logic             en,
  input  tlik_pkg::cordic_t d_i,
  output tlik_pkg::cordic_t d_r
);
  import tlik_pkg::*;

  localparam logic signed [ZW-1:0] STEP = ZW'(atan_q16(I));

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  cordic_t              d_nxt;

  always_comb begin
    xs = d_i.x >>> I;
    ys = d_i.y >>> I;
    if (!d_i.y[XW-1]) begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + STEP;
    end else begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== design/two_link_arm_inverse_kinematics_unit.sv =====
// Throughput: one target per cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output and out_tready is low.
// Depth is set by the 30 square-root digit cells and the CORDIC cell chain.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: base at the origin, both link lengths 2560 (10.0).
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_unit
// Joint angles of an equal-length two-link arm from a target point, built as
// chains of square-root and CORDIC cells.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // target_x[23:0], target_y[47:24], target_z[71:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // reachable[0], elbow[16:1],
                                  // shoulder_angle[34:17], zero fill
);
  import tlik_pkg::*;

  localparam int NS    = CORDIC_STAGES;
  localparam int DEPTH = 34 + NS;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  logic signed [23:0] base_x_r, base_y_r, base_z_r;
  logic [22:0] upper_r, fore_r;
  logic [45:0] u2_r;
  logic [47:0] r2_r;
  logic [23:0] reach_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= '0;
      base_y_r <= '0;
      base_z_r <= '0;
      upper_r  <= 23'd2560;
      fore_r   <= 23'd2560;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_X: base_x_r <= cfg_data;
        REG_BASE_Y: base_y_r <= cfg_data;
        REG_BASE_Z: base_z_r <= cfg_data;
        REG_UPPER:  upper_r  <= cfg_data[22:0];
        REG_FORE:   fore_r   <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  assign reach_len = {1'b0, upper_r} + {1'b0, fore_r};

  // Squares of the link geometry; the user must let these registers settle while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    u2_r <= upper_r * upper_r;
    r2_r <= reach_len * reach_len;
  end

  logic [DEPTH-1:0] vld_r;

  // Stage 1: offsets.
  logic signed [24:0] dx_r, dy_r, dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= 25'(signed'(in_tdata[23:0]))  - 25'(base_x_r);
      dy_r <= 25'(signed'(in_tdata[47:24])) - 25'(base_y_r);
      dz_r <= 25'(signed'(in_tdata[71:48])) - 25'(base_z_r);
    end
  end

  // Stage 2: squares and elevation pre-rotation.
  logic signed [49:0] sqx, sqy, sqz;
  logic [49:0] sqx_r, sqy_r, sqz_r;
  cordic_t     einit_nxt;
  cordic_t     einit_r [0:32];
  logic        ezero_r [0:32];

  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;
  assign sqz = dz_r * dz_r;

  always_comb begin
    einit_nxt.x = XW'(dz_r) <<< 16;
    einit_nxt.y = XW'(dy_r) <<< 16;
    einit_nxt.z = '0;
    if (dz_r < 0) begin
      if (dy_r >= 0) begin
        einit_nxt.x = XW'(dy_r) <<< 16;
        einit_nxt.y = (-XW'(dz_r)) <<< 16;
        einit_nxt.z = ANG90;
      end else begin
        einit_nxt.x = (-XW'(dy_r)) <<< 16;
        einit_nxt.y = XW'(dz_r) <<< 16;
        einit_nxt.z = -ANG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r      <= sqx;
      sqy_r      <= sqy;
      sqz_r      <= sqz;
      einit_r[0] <= einit_nxt;
      ezero_r[0] <= (dy_r == 0) && (dz_r == 0);
    end
  end

  // Stage 3: squared distance.
  logic [49:0] s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_r        <= sqx_r + sqy_r + sqz_r;
      einit_r[1] <= einit_r[0];
      ezero_r[1] <= ezero_r[0];
    end
  end

  // Stage 4: reach tests and square-root radicands.
  logic [47:0] four_u2;
  logic [47:0] diff;
  sqrt_t       sa [0:30];
  sqrt_t       sb [0:30];
  logic        ok_r [0:30];

  assign four_u2 = {u2_r, 2'b00};
  assign diff    = four_u2 - s_r[47:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0].v    <= {s_r[47:0], 12'd0};
      sa[0].rem  <= '0;
      sa[0].q    <= '0;
      sb[0].v    <= {diff, 12'd0};
      sb[0].rem  <= '0;
      sb[0].q    <= '0;
      ok_r[0]    <= (s_r < {2'b00, r2_r}) && (s_r < {2'b00, four_u2});
      einit_r[2] <= einit_r[1];
      ezero_r[2] <= ezero_r[1];
    end
  end

  // Square-root digit chains, one result bit per cell, most significant first.
  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_sqrt
      tlik_sqrt_cell #(.BIT(QW - 1 - k)) u_sa (
        .clk(clk), .en(en), .d_i(sa[k]), .d_r(sa[k+1])
      );
      tlik_sqrt_cell #(.BIT(QW - 1 - k)) u_sb (
        .clk(clk), .en(en), .d_i(sb[k]), .d_r(sb[k+1])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          ok_r[k+1]    <= ok_r[k];
          einit_r[k+3] <= einit_r[k+2];
          ezero_r[k+3] <= ezero_r[k+2];
        end
      end
    end
  endgenerate

  // CORDIC chains: half elbow angle and elevation side by side.
  cordic_t ca [0:NS];
  cordic_t ce [0:NS];
  flags_t  fl_r [1:NS];
  flags_t  fl0;

  always_comb begin
    ca[0].x  = XW'({sb[30].q, 16'd0});
    ca[0].y  = XW'({sa[30].q, 16'd0});
    ca[0].z  = '0;
    ce[0]    = einit_r[32];
    fl0.ok    = ok_r[30];
    fl0.ezero = ezero_r[32];
  end

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_cordic
      tlik_cordic_cell #(.I(i)) u_ca (
        .clk(clk), .en(en), .d_i(ca[i]), .d_r(ca[i+1])
      );
      tlik_cordic_cell #(.I(i)) u_ce (
        .clk(clk), .en(en), .d_i(ce[i]), .d_r(ce[i+1])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          fl_r[i+1] <= (i == 0) ? fl0 : fl_r[(i == 0) ? 1 : i];
        end
      end
    end
  endgenerate

  // Output stage: clamp, round half up to 1/256 degree, clamp again.
  logic signed [ZW-1:0] a_c, e_c;
  logic signed [ZW:0]   elbow_w, shoulder_w;
  logic signed [ZW:0]   elbow_c, shoulder_c;

  always_comb begin
    if (ca[NS].z < 0) begin
      a_c = '0;
    end else if (ca[NS].z > ANG90) begin
      a_c = ANG90;
    end else begin
      a_c = ca[NS].z;
    end
    if (fl_r[NS].ezero) begin
      e_c = '0;
    end else if (ce[NS].z < -ANG180) begin
      e_c = -ANG180;
    end else if (ce[NS].z > ANG180) begin
      e_c = ANG180;
    end else begin
      e_c = ce[NS].z;
    end
    elbow_w    = (28'(ANG180) - (28'(a_c) <<< 1) + 28'sd128) >>> 8;
    shoulder_w = (28'(e_c) + 28'(a_c) + 28'sd128) >>> 8;
    if (elbow_w < 0) begin
      elbow_c = '0;
    end else if (elbow_w > ELBOW_MAX) begin
      elbow_c = ELBOW_MAX;
    end else begin
      elbow_c = elbow_w;
    end
    if (shoulder_w < SHOULDER_MIN) begin
      shoulder_c = SHOULDER_MIN;
    end else if (shoulder_w > SHOULDER_MAX) begin
      shoulder_c = SHOULDER_MAX;
    end else begin
      shoulder_c = shoulder_w;
    end
  end

  logic        reach_r;
  logic [15:0] elbow_r;
  logic [17:0] shoulder_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      reach_r    <= fl_r[NS].ok;
      elbow_r    <= fl_r[NS].ok ? elbow_c[15:0] : 16'd0;
      shoulder_r <= fl_r[NS].ok ? shoulder_c[17:0] : 18'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_tvalid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, shoulder_r, elbow_r, reach_r};

  // A target out of reach carries zero angles.
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[34:1] == 34'd0)
    else $error("unreachable result with nonzero angles");

  // Elbow angle stays within 0 to 180 degrees.
  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:1] <= 16'd46080)
    else $error("elbow angle out of range");

  // The pipeline holds its occupancy while the output is stalled.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics unit testbench
// Streams target points through the unit under several shoulder positions and
// link lengths, predicts the reach flag and both joint angles in integer
// arithmetic, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlik_pkg::*;

  localparam int STAGES  = 16;
  localparam int LATENCY = 35 + STAGES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Field order follows the result bus, lowest bits last.
  typedef struct packed {
    logic signed [17:0]  shoulder;
    logic [15:0]         elbow;
    logic                reachable;
  } joint_result_t;

  // Scoreboard: the arm geometry and the queue of predicted joint angles.
  class joint_scoreboard;
    longint base_x, base_y, base_z, upper_len, fore_len;
    joint_result_t pending[$];
    int mismatches;

    function new();
      base_x = 0; base_y = 0; base_z = 0; upper_len = 2560; fore_len = 2560;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_BASE_X: base_x = longint'(signed'(val));
        REG_BASE_Y: base_y = longint'(signed'(val));
        REG_BASE_Z: base_z = longint'(signed'(val));
        REG_UPPER:  upper_len = longint'(val[22:0]);
        REG_FORE:   fore_len = longint'(val[22:0]);
        default: ;
      endcase
    endfunction

    function longint floor_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return longint'(root);
    endfunction

    function longint angle_of(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 90 * 65536;
        end else begin
          t = x; x = -y; y = t; z = -90 * 65536;
        end
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += longint'(atan_q16(i));
        end else begin
          x -= ys; y += xs; z -= longint'(atan_q16(i));
        end
      end
      return z;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_target(logic [71:0] d);
      longint dx, dy, dz, half, elev, elb, sh;
      longint unsigned s, reach, four_u2;
      joint_result_t r;
      dx = longint'(signed'(d[23:0])) - base_x;
      dy = longint'(signed'(d[47:24])) - base_y;
      dz = longint'(signed'(d[71:48])) - base_z;
      s = dx * dx + dy * dy + dz * dz;
      reach = upper_len + fore_len;
      four_u2 = 4 * upper_len * upper_len;
      r = '0;
      if (!(s >= reach * reach || s >= four_u2)) begin
        half = angle_of(floor_sqrt(s * 4096), floor_sqrt((four_u2 - s) * 4096));
        half = clip(half, 0, 90 * 65536);
        elev = clip(angle_of(dy, dz), -180 * 65536, 180 * 65536);
        elb = clip((180 * 65536 - 2 * half + 128) >>> 8, 0, 46080);
        sh = clip((elev + half + 128) >>> 8, -46080, 69120);
        r.reachable = 1'b1;
        r.elbow = elb[15:0];
        r.shoulder = sh[17:0];
      end
      pending = {pending, r};
    endfunction

    function void check_result(logic [39:0] d);
      joint_result_t got, want;
      got = d[34:0];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer %h", d);
        return;
      end
      want = pending.pop_front();
      if (got !== want || d[39:35] !== 5'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected reach %b elbow %0d shoulder %0d, got %b %0d %0d",
                   want.reachable, want.elbow, want.shoulder,
                   got.reachable, got.elbow, got.shoulder);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_tvalid = 1'b0, in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [39:0] out_tdata;

  joint_scoreboard board = new();
  int send_idle_pct = 0, recv_idle_pct = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  two_link_arm_inverse_kinematics_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stall, checks on the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (rst_n && (out_tvalid && out_tready || in_tvalid && in_tready || cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // cfg_valid is lowered after each write, so writes never follow back to back on the configuration port.
  task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // in_tvalid stays high after a transfer so targets can follow back to back;
  // an idle gap or drain() lowers it.
  task automatic send_target(logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {z, y, x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_target({z, y, x});
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Offsets drawn evenly around the base; random_targets sets a span just beyond the reach sphere.
  function automatic logic [23:0] near(longint base, longint span);
    longint v;
    v = base + $signed($urandom_range(2 * span)) - span;
    return v[23:0];
  endfunction

  task automatic random_targets(int n);
    longint span;
    for (int i = 0; i < n; i++) begin
      span = 2 * board.upper_len + 2;
      if ($urandom_range(9) == 0)
        send_target(24'($urandom), 24'($urandom), 24'($urandom));
      else
        send_target(near(board.base_x, span), near(board.base_y, span),
                    near(board.base_z, span));
    end
  endtask

  task automatic set_geometry(logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                              logic [23:0] up, logic [23:0] fo);
    write_cfg(REG_BASE_X, bx);
    write_cfg(REG_BASE_Y, by);
    write_cfg(REG_BASE_Z, bz);
    write_cfg(REG_UPPER, up);
    write_cfg(REG_FORE, fo);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: origin, axes, reach boundary, extreme coordinates.
    send_target(24'sd0, 24'sd0, 24'sd0);
    send_target(24'sd0, 24'sd0, 24'sd100);
    send_target(24'sd0, 24'sd0, -24'sd100);
    send_target(24'sd0, 24'sd100, 24'sd0);
    send_target(24'sd0, -24'sd100, 24'sd0);
    send_target(24'sd100, 24'sd0, 24'sd0);
    send_target(24'sd0, 24'sd0, 24'sd5119);
    send_target(24'sd0, 24'sd0, 24'sd5120);
    send_target(24'sd0, 24'sd3000, -24'sd3000);
    send_target(-24'sd8388608, -24'sd8388608, -24'sd8388608);
    send_target(24'sd8388607, 24'sd8388607, 24'sd8388607);
    send_target(-24'sd1, 24'sd1, -24'sd1);
    drain();
    // Unequal links: fore shorter limits reach; zero upper is always out.
    set_geometry(24'd100, -24'sd200, 24'd300, 24'd4000, 24'd1000);
    send_target(24'd100, -24'sd200, 24'd5299);
    send_target(24'd100, -24'sd200, 24'd5300);
    send_target(24'd100, 24'd800, 24'd300);
    drain();
    write_cfg(REG_UPPER, 24'd0);
    send_target(24'd100, -24'sd200, 24'd300);
    send_target(24'd101, -24'sd200, 24'd300);
    drain();
    write_cfg(REG_UNUSED, 24'hFFFFFF);
    set_geometry(24'h800000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h7FFFFF);
    send_target(24'h800000, 24'h7FFFFF, 24'h800000);
    send_target(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    drain();

    send_idle_pct = 35; recv_idle_pct = 51;
    set_geometry(24'd0, 24'd0, 24'd0, 24'd2560, 24'd2560);
    random_targets(160);
    drain();
    set_geometry(24'($urandom), 24'($urandom), 24'($urandom), 24'd1, 24'd1);
    random_targets(80);
    drain();
    send_idle_pct = 51; recv_idle_pct = 35;
    set_geometry(24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom_range(1, 65535)), 24'($urandom_range(1, 65535)));
    random_targets(160);
    drain();
    set_geometry(24'($urandom), 24'($urandom), 24'($urandom), 24'h7FFFFF,
                 24'($urandom_range(1, 8388607)));
    random_targets(80);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_geometry(24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom_range(1, 20000)), 24'($urandom_range(1, 20000)));
    random_targets(220);
    drain();
    set_geometry(24'd0, 24'd0, 24'd0, 24'd2560, 24'd1500);
    random_targets(220);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
